[src/lbps_pkg.sv]
// lbps_pkg: shared types and constants of the leaky bucket packet shaper
// transaction structs, command, result kind, register index and state codes
// no dependencies
package lbps_pkg;

  localparam int QUEUE_DEPTH_DEFAULT = 16;
  localparam int SIZE_BITS_DEFAULT   = 16;
  localparam int RESULT_LIMIT        = 16;
  localparam int RESULT_COUNT_BITS   = 5;
  localparam int SIZE_FIELD_BITS     = 16;
  localparam int COUNT_FIELD_BITS    = 5;
  localparam int CFG_INDEX_BITS      = 2;
  localparam int CFG_DATA_BITS       = 16;

  typedef enum logic {
    CMD_PUSH = 1'b0,
    CMD_TICK = 1'b1
  } cmd_t;

  typedef enum logic [2:0] {
    KIND_ACCEPTED   = 3'd0,
    KIND_TOO_BIG    = 3'd1,
    KIND_QUEUE_FULL = 3'd2,
    KIND_RELEASED   = 3'd3,
    KIND_NO_RELEASE = 3'd4
  } kind_t;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_BUCKET_CAPACITY = 2'd0,
    REG_QUEUE_LIMIT     = 2'd1,
    REG_PERIOD_TICKS    = 2'd2
  } cfg_reg_t;

  typedef enum logic {
    ST_IDLE  = 1'b0,
    ST_DRAIN = 1'b1
  } state_t;

  typedef struct packed {
    cmd_t                       command;
    logic [SIZE_FIELD_BITS-1:0] packet_size;
  } in_t;

  typedef struct packed {
    kind_t                       kind;
    logic [SIZE_FIELD_BITS-1:0]  released_size;
    logic [COUNT_FIELD_BITS-1:0] queue_count;
    logic [SIZE_FIELD_BITS-1:0]  space_left;
    logic                        last;
  } out_t;

endpackage

[src/lbps_queue_mem.sv]
// lbps_queue_mem: packet size queue storage, one write and one read port
// synchronous registered read, no reset of contents
// no dependencies
module lbps_queue_mem #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

[src/lbps_cfg.sv]
// lbps_cfg: configuration registers with write channel
// normalizes capacity, queue limit and period for the controller
// depends on lbps_pkg
module lbps_cfg #(
  parameter int QUEUE_DEPTH = lbps_pkg::QUEUE_DEPTH_DEFAULT,
  parameter int SIZE_BITS   = lbps_pkg::SIZE_BITS_DEFAULT
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    cfg_valid,
  output logic                                    cfg_ready,
  input  logic [lbps_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
  input  logic [lbps_pkg::CFG_DATA_BITS-1:0]      cfg_data,
  output logic [SIZE_BITS-1:0]                    cap,
  output logic [$clog2(QUEUE_DEPTH+1)-1:0]        limit,
  output logic [lbps_pkg::SIZE_FIELD_BITS-1:0]    period
);

  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int SF = lbps_pkg::SIZE_FIELD_BITS;
  localparam int LF = lbps_pkg::COUNT_FIELD_BITS;

  logic [SF-1:0]           bucket_capacity;
  logic [LF-1:0]           queue_limit;
  logic [SF-1:0]           period_ticks;
  logic [LF-1:0]           limit_nz;
  logic [SIZE_BITS+SF-1:0] cap_ext;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      bucket_capacity <= '0;
      queue_limit     <= LF'(16);
      period_ticks    <= SF'(1);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        lbps_pkg::REG_BUCKET_CAPACITY: bucket_capacity <= cfg_data[SF-1:0];
        lbps_pkg::REG_QUEUE_LIMIT:     queue_limit     <= cfg_data[LF-1:0];
        lbps_pkg::REG_PERIOD_TICKS:    period_ticks    <= cfg_data[SF-1:0];
        default: ;
      endcase
    end
  end

  assign cap_ext  = (SIZE_BITS + SF)'(bucket_capacity);
  assign cap      = cap_ext[SIZE_BITS-1:0];
  assign limit_nz = (queue_limit == '0) ? LF'(1) : queue_limit;
  assign limit    = (32'(limit_nz) > 32'(QUEUE_DEPTH)) ? CW'(QUEUE_DEPTH) : CW'(limit_nz);
  assign period   = (period_ticks == '0) ? SF'(1) : period_ticks;

endmodule

[src/lbps_ctrl.sv]
// lbps_ctrl: queue pointers, countdown, bucket space and drain sequencer
// reads the queue memory one head entry per cycle and emits results
// depends on lbps_pkg
module lbps_ctrl #(
  parameter int QUEUE_DEPTH = lbps_pkg::QUEUE_DEPTH_DEFAULT,
  parameter int SIZE_BITS   = lbps_pkg::SIZE_BITS_DEFAULT
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  input  lbps_pkg::in_t                         request,
  output logic                                  busy,
  input  logic [SIZE_BITS-1:0]                  cap,
  input  logic [$clog2(QUEUE_DEPTH+1)-1:0]      limit,
  input  logic [lbps_pkg::SIZE_FIELD_BITS-1:0]  period,
  output logic                                  wr_en,
  output logic [$clog2(QUEUE_DEPTH)-1:0]        wr_addr,
  output logic [SIZE_BITS-1:0]                  wr_data,
  output logic [$clog2(QUEUE_DEPTH)-1:0]        rd_addr,
  input  logic [SIZE_BITS-1:0]                  rd_data,
  output logic                                  result_valid,
  output lbps_pkg::out_t                        result
);

  localparam int HW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int NW = lbps_pkg::RESULT_COUNT_BITS;
  localparam int SF = lbps_pkg::SIZE_FIELD_BITS;
  localparam int LF = lbps_pkg::COUNT_FIELD_BITS;

  lbps_pkg::state_t state, state_next;

  logic [HW-1:0]        head, head_next;
  logic [CW-1:0]        count, count_next;
  logic [SF-1:0]        countdown, countdown_next;
  logic [SIZE_BITS-1:0] space, space_next;
  logic [NW-1:0]        n, n_next;
  logic                 pend_valid, pend_valid_next;
  logic [SIZE_BITS-1:0] pend_size, pend_size_next;
  logic [CW-1:0]        pend_count, pend_count_next;
  logic [SIZE_BITS-1:0] pend_space, pend_space_next;
  logic                 res_valid, res_valid_next;
  lbps_pkg::out_t       res, res_next;

  logic                 accept;
  logic                 drain_start;
  logic                 fit;
  logic [SIZE_BITS+SF-1:0] size_ext;
  logic [SIZE_BITS-1:0] size_in;
  logic [HW:0]          tail_sum;
  logic [HW-1:0]        tail;
  logic [HW-1:0]        head_inc;
  logic [SIZE_BITS-1:0] space_after;

  function automatic logic [SF-1:0] to_field(input logic [SIZE_BITS-1:0] v);
    logic [SIZE_BITS+SF-1:0] e;
    e = (SIZE_BITS + SF)'(v);
    return e[SF-1:0];
  endfunction

  function automatic logic [LF-1:0] to_count(input logic [CW-1:0] v);
    logic [CW+LF-1:0] e;
    e = (CW + LF)'(v);
    return e[LF-1:0];
  endfunction

  assign busy        = (state != lbps_pkg::ST_IDLE);
  assign accept      = start && !busy;
  assign drain_start = accept && (request.command == lbps_pkg::CMD_TICK) && (countdown == '0);

  assign size_ext = (SIZE_BITS + SF)'(request.packet_size);
  assign size_in  = size_ext[SIZE_BITS-1:0];

  assign tail_sum = (HW + 1)'(head) + (HW + 1)'(count);
  assign tail     = (tail_sum >= (HW + 1)'(QUEUE_DEPTH)) ?
                    HW'(tail_sum - (HW + 1)'(QUEUE_DEPTH)) : HW'(tail_sum);
  assign head_inc = (head == HW'(QUEUE_DEPTH - 1)) ? '0 : head + 1'b1;

  assign fit = (count != '0) && (n != NW'(lbps_pkg::RESULT_LIMIT)) && (rd_data <= space);
  assign space_after = space - rd_data;

  always_comb begin
    state_next = state;
    case (state)
      lbps_pkg::ST_IDLE: begin
        if (drain_start) begin
          state_next = lbps_pkg::ST_DRAIN;
        end
      end
      lbps_pkg::ST_DRAIN: begin
        if (!fit) begin
          state_next = lbps_pkg::ST_IDLE;
        end
      end
      default: state_next = lbps_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    head_next       = head;
    count_next      = count;
    countdown_next  = countdown;
    space_next      = space;
    n_next          = n;
    pend_valid_next = pend_valid;
    pend_size_next  = pend_size;
    pend_count_next = pend_count;
    pend_space_next = pend_space;
    res_valid_next  = 1'b0;
    res_next        = res;
    wr_en           = 1'b0;
    case (state)
      lbps_pkg::ST_IDLE: begin
        if (accept) begin
          res_next.released_size = '0;
          res_next.last          = 1'b1;
          if (request.command == lbps_pkg::CMD_PUSH) begin
            res_valid_next = 1'b1;
            if (size_in > cap) begin
              res_next.kind = lbps_pkg::KIND_TOO_BIG;
            end else if (count >= limit) begin
              res_next.kind = lbps_pkg::KIND_QUEUE_FULL;
            end else begin
              wr_en         = 1'b1;
              count_next    = count + 1'b1;
              res_next.kind = lbps_pkg::KIND_ACCEPTED;
            end
            res_next.queue_count = to_count(count_next);
            res_next.space_left  = to_field(space);
          end else if (countdown != '0) begin
            res_valid_next       = 1'b1;
            countdown_next       = countdown - 1'b1;
            res_next.kind        = lbps_pkg::KIND_NO_RELEASE;
            res_next.queue_count = to_count(count);
            res_next.space_left  = to_field(space);
          end else begin
            countdown_next  = period - 1'b1;
            space_next      = cap;
            n_next          = '0;
            pend_valid_next = 1'b0;
          end
        end
      end
      lbps_pkg::ST_DRAIN: begin
        if (fit) begin
          space_next             = space_after;
          head_next              = head_inc;
          count_next             = count - 1'b1;
          n_next                 = n + 1'b1;
          pend_valid_next        = 1'b1;
          pend_size_next         = rd_data;
          pend_count_next        = count - 1'b1;
          pend_space_next        = space_after;
          res_valid_next         = pend_valid;
          res_next.kind          = lbps_pkg::KIND_RELEASED;
          res_next.released_size = to_field(pend_size);
          res_next.queue_count   = to_count(pend_count);
          res_next.space_left    = to_field(pend_space);
          res_next.last          = 1'b0;
        end else begin
          pend_valid_next = 1'b0;
          res_valid_next  = 1'b1;
          res_next.last   = 1'b1;
          if (pend_valid) begin
            res_next.kind          = lbps_pkg::KIND_RELEASED;
            res_next.released_size = to_field(pend_size);
            res_next.queue_count   = to_count(pend_count);
            res_next.space_left    = to_field(pend_space);
          end else begin
            res_next.kind          = lbps_pkg::KIND_NO_RELEASE;
            res_next.released_size = '0;
            res_next.queue_count   = to_count(count);
            res_next.space_left    = to_field(space);
          end
        end
      end
      default: ;
    endcase
  end

  assign wr_addr = tail;
  assign wr_data = size_in;
  assign rd_addr = head_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= lbps_pkg::ST_IDLE;
      head       <= '0;
      count      <= '0;
      countdown  <= '0;
      space      <= '0;
      n          <= '0;
      pend_valid <= 1'b0;
      res_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      head       <= head_next;
      count      <= count_next;
      countdown  <= countdown_next;
      space      <= space_next;
      n          <= n_next;
      pend_valid <= pend_valid_next;
      res_valid  <= res_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    pend_size  <= pend_size_next;
    pend_count <= pend_count_next;
    pend_space <= pend_space_next;
    res        <= res_next;
  end

  assign result_valid = res_valid;
  assign result       = res;

  a_not_last_followed: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res.last |=> res_valid)
    else $error("non-final result not followed by another");

  a_release_from_drain: assert property (@(posedge clk) disable iff (rst)
    res_valid && (res.kind == lbps_pkg::KIND_RELEASED) |-> $past(state) == lbps_pkg::ST_DRAIN)
    else $error("release result outside a drain");

  a_push_counts: assert property (@(posedge clk) disable iff (rst)
    res_valid && (res.kind == lbps_pkg::KIND_ACCEPTED) |-> count == $past(count) + 1'b1)
    else $error("accepted push did not grow the queue");

  a_idle_no_pending: assert property (@(posedge clk) disable iff (rst)
    (state == lbps_pkg::ST_IDLE) |-> !pend_valid && (count <= CW'(QUEUE_DEPTH)))
    else $error("pending release or count overflow while idle");

endmodule

[src/leaky_bucket_packet_shaper_unit.sv]
// leaky_bucket_packet_shaper_unit: push or non-draining tick result is strobed the next cycle
// drain tick: busy until the drain ends; results one per cycle, one per released packet with the
// last flagged, or one no-release if nothing fits; one read per head entry, one to mark last
// no backpressure on results; synchronous reset clears pointers and counters, config to defaults
// queue memory contents are not cleared
// depends on lbps_pkg, lbps_cfg, lbps_queue_mem, lbps_ctrl
module leaky_bucket_packet_shaper_unit #(
  parameter int QUEUE_DEPTH = lbps_pkg::QUEUE_DEPTH_DEFAULT,
  parameter int SIZE_BITS   = lbps_pkg::SIZE_BITS_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  lbps_pkg::in_t                       request,
  output logic                                busy,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [lbps_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [lbps_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  output logic                                result_valid,
  output lbps_pkg::out_t                      result
);

  localparam int HW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic [SIZE_BITS-1:0]                 cap;
  logic [CW-1:0]                        limit;
  logic [lbps_pkg::SIZE_FIELD_BITS-1:0] period;
  logic                                 wr_en;
  logic [HW-1:0]                        wr_addr;
  logic [SIZE_BITS-1:0]                 wr_data;
  logic [HW-1:0]                        rd_addr;
  logic [SIZE_BITS-1:0]                 rd_data;

  lbps_cfg #(
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .SIZE_BITS  (SIZE_BITS)
  ) u_cfg (
    .clk      (clk),
    .rst      (rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .cap      (cap),
    .limit    (limit),
    .period   (period)
  );

  lbps_queue_mem #(
    .DEPTH(QUEUE_DEPTH),
    .WIDTH(SIZE_BITS)
  ) u_mem (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  lbps_ctrl #(
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .SIZE_BITS  (SIZE_BITS)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .request     (request),
    .busy        (busy),
    .cap         (cap),
    .limit       (limit),
    .period      (period),
    .wr_en       (wr_en),
    .wr_addr     (wr_addr),
    .wr_data     (wr_data),
    .rd_addr     (rd_addr),
    .rd_data     (rd_data),
    .result_valid(result_valid),
    .result      (result)
  );

endmodule
